/* rtl/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the voice pool allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int OP_W    = 2;
  localparam int SND_W   = 7;
  localparam int SEL_W   = 3;
  localparam int STAMP_W = 32;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_START    = 2'd0,
    OP_FINISH   = 2'd1,
    OP_STOP_ALL = 2'd2,
    OP_RESERVE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_LAST,
    B_DONE
  } b_state_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_e              op;
    logic [SEL_W-1:0] sel;
    logic             snd_ok;
    logic             res_hit;
    logic [SEL_W-1:0] res_voice;
  } q_entry_t;

endpackage

/* rtl/vpa_front.sv */
// ----------------------------------------------------------------------------
// vpa_front
// Accepts requests, applies reservation writes and looks up the reservation
// of a starting sound.
// ----------------------------------------------------------------------------
module vpa_front import vpa_pkg::*; #(
  parameter int NUM_VOICES = 8,
  parameter int NUM_SOUNDS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OP_W-1:0]  opcode_i,
  input  logic [SND_W-1:0] sound_id_i,
  input  logic [SEL_W-1:0] voice_sel_i,
  input  logic             reserve_on_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output q_entry_t         q_entry_o
);

  // Sound numbers above the input field's range can never be addressed.
  localparam int SD  = (NUM_SOUNDS < (1 << SND_W)) ? NUM_SOUNDS : (1 << SND_W);
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

  logic [SEL_W-1:0] res_mem [SD];
  logic [SD-1:0]    res_vld_q;
  logic [SEL_W-1:0] res_rd_q;

  logic             f_valid_q;
  op_e              f_op_q;
  logic [SEL_W-1:0] f_sel_q;
  logic             f_ok_q;
  logic             f_rv_q;

  logic             accept;
  logic             snd_ok;
  logic [SAW-1:0]   addr;
  op_e              op_in;

  assign op_in      = op_e'(opcode_i);
  assign snd_ok     = 32'(sound_id_i) < NUM_SOUNDS;
  assign addr       = SAW'(sound_id_i);
  assign in_stall_o = f_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = f_valid_q && !q_full_i;

  always_comb begin
    q_entry_o.op        = f_op_q;
    q_entry_o.sel       = f_sel_q;
    q_entry_o.snd_ok    = f_ok_q;
    q_entry_o.res_hit   = f_rv_q && (32'(res_rd_q) < NUM_VOICES);
    q_entry_o.res_voice = res_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      res_vld_q <= '0;
    end else begin
      if (accept) begin
        f_valid_q <= 1'b1;
      end else if (q_push_o) begin
        f_valid_q <= 1'b0;
      end
      if (accept && op_in == OP_RESERVE && snd_ok) begin
        res_vld_q[addr] <= reserve_on_i;
      end
    end
  end

  // An entry's voice is only ever used while its valid bit is set, so the
  // table itself needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept && op_in == OP_RESERVE && snd_ok) begin
      res_mem[addr] <= voice_sel_i;
    end
    if (accept) begin
      res_rd_q <= res_mem[addr];
      f_op_q   <= op_in;
      f_sel_q  <= voice_sel_i;
      f_ok_q   <= snd_ok;
      f_rv_q   <= snd_ok && res_vld_q[addr];
    end
  end

endmodule

/* rtl/vpa_queue.sv */
// ----------------------------------------------------------------------------
// vpa_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module vpa_queue import vpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  input  logic     pop_i,
  output q_entry_t pop_data_o,
  output logic     full_o,
  output logic     empty_o
);

  q_entry_t         mem_q [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_q;
  logic [Q_AW-1:0]  rd_ptr_q;
  logic [Q_AW:0]    count_q;

  function automatic logic [Q_AW-1:0] ptr_next(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = count_q == (Q_AW + 1)'(Q_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/vpa_back.sv */
// ----------------------------------------------------------------------------
// vpa_back
// Executes requests: holds voice state, scans the pool for a free or the
// oldest voice, and registers the result.
// ----------------------------------------------------------------------------
module vpa_back import vpa_pkg::*; #(
  parameter int NUM_VOICES   = 8,
  parameter int NUM_RESERVED = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  q_entry_t         q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SEL_W-1:0] voice_out_o,
  output logic             stole_busy_o,
  output logic             granted_o
);

  localparam int VW = $clog2(NUM_VOICES);
  localparam bit POOL_NONEMPTY = NUM_RESERVED < NUM_VOICES;

  b_state_e state_q, state_d;

  q_entry_t            cur_q;
  logic [NUM_VOICES-1:0] busy_q;
  logic [STAMP_W-1:0]  stamp_mem [NUM_VOICES];
  logic [STAMP_W-1:0]  counter_q;

  logic [VW-1:0]       scan_q;
  logic                cmp_vld_q;
  logic [VW-1:0]       cmp_idx_q;
  logic [STAMP_W-1:0]  stamp_rd_q;
  logic                free_found_q;
  logic [VW-1:0]       free_idx_q;
  logic [VW-1:0]       old_idx_q;
  logic [STAMP_W-1:0]  old_stamp_q;

  logic                out_valid_q;
  logic [SEL_W-1:0]    voice_q;
  logic                stole_q;
  logic                grant_q;

  logic                needs_scan;
  logic                scan_step;
  logic                done_fire;
  logic                grant;
  logic [VW-1:0]       chosen;
  logic                sel_ok;
  logic [VW-1:0]       sel_idx;

  assign needs_scan = (q_entry_i.op == OP_START) && q_entry_i.snd_ok &&
                      !q_entry_i.res_hit && POOL_NONEMPTY;

  assign grant   = (cur_q.op == OP_START) && cur_q.snd_ok &&
                   (cur_q.res_hit || POOL_NONEMPTY);
  assign chosen  = cur_q.res_hit ? VW'(cur_q.res_voice) :
                   (free_found_q ? free_idx_q : old_idx_q);
  assign sel_ok  = 32'(cur_q.sel) < NUM_VOICES;
  assign sel_idx = VW'(cur_q.sel);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = needs_scan ? B_SCAN : B_DONE;
        end
      end
      B_SCAN: begin
        if (scan_q == VW'(NUM_VOICES - 1)) begin
          state_d = B_LAST;
        end
      end
      B_LAST: state_d = B_DONE;
      B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop_o   = 1'b0;
    scan_step = 1'b0;
    done_fire = 1'b0;
    case (state_q)
      B_IDLE:  q_pop_o   = !q_empty_i;
      B_SCAN:  scan_step = 1'b1;
      B_LAST:  scan_step = 1'b0;
      B_DONE:  done_fire = !out_valid_q || !out_stall_i;
      default: q_pop_o   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      busy_q      <= '0;
      counter_q   <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= scan_step;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (done_fire) begin
        case (cur_q.op)
          OP_START: begin
            if (grant) begin
              busy_q[chosen] <= 1'b1;
              counter_q      <= counter_q + 1'b1;
            end
          end
          OP_FINISH: begin
            if (sel_ok) begin
              busy_q[sel_idx] <= 1'b0;
            end
          end
          OP_STOP_ALL: busy_q <= '0;
          default: busy_q <= busy_q;
        endcase
      end
    end
  end

  // Scan bookkeeping and the stamp memory. Every pool stamp is written by a
  // start before all pool voices can be busy, so stamps need no reset.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q        <= q_entry_i;
      scan_q       <= VW'(NUM_RESERVED);
      free_found_q <= 1'b0;
      old_idx_q    <= VW'(NUM_RESERVED);
      old_stamp_q  <= '1;
    end
    if (scan_step) begin
      stamp_rd_q <= stamp_mem[scan_q];
      cmp_idx_q  <= scan_q;
      scan_q     <= scan_q + 1'b1;
    end
    if (cmp_vld_q) begin
      if (!busy_q[cmp_idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end
      // Strict compare keeps the lower index on equal stamps.
      if (stamp_rd_q < old_stamp_q) begin
        old_stamp_q <= stamp_rd_q;
        old_idx_q   <= cmp_idx_q;
      end
    end
    if (done_fire && grant) begin
      stamp_mem[chosen] <= counter_q + 1'b1;
    end
    if (done_fire) begin
      if (cur_q.op == OP_START) begin
        voice_q <= grant ? SEL_W'(chosen) : '0;
        stole_q <= grant && busy_q[chosen];
      end else begin
        voice_q <= cur_q.sel;
        stole_q <= 1'b0;
      end
      grant_q <= grant;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign voice_out_o  = voice_q;
  assign stole_busy_o = stole_q;
  assign granted_o    = grant_q;

endmodule

/* rtl/voice_pool_allocator.sv */
// ----------------------------------------------------------------------------
// voice_pool_allocator
// Grants playback voices to sound starts, stealing the oldest pool voice
// when none is free.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on in_valid_i/in_stall_o with opcode_i, sound_id_i,
// voice_sel_i and reserve_on_i, and is taken at an edge where in_valid_i is
// high and in_stall_o is low. Every request returns exactly one result on
// out_valid_o/out_stall_i with voice_out_o, stole_busy_o and granted_o, in
// request order.
// A plain request passes the back end directly; a start that searches the pool
// scans the pool voices first: the search reads one start stamp per cycle from
// the stamp memory. A two-entry queue lets the front take requests meanwhile.
// Reset clears all voices, the start counter and every reservation at once;
// no clearing pass is needed. While the receiver stalls, the result is held
// and the block keeps taking requests until its queue fills.
// ----------------------------------------------------------------------------
module voice_pool_allocator import vpa_pkg::*; #(
  parameter int NUM_VOICES   = 8,
  parameter int NUM_RESERVED = 2,
  parameter int NUM_SOUNDS   = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OP_W-1:0]  opcode_i,
  input  logic [SND_W-1:0] sound_id_i,
  input  logic [SEL_W-1:0] voice_sel_i,
  input  logic             reserve_on_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SEL_W-1:0] voice_out_o,
  output logic             stole_busy_o,
  output logic             granted_o
);

  q_entry_t push_data;
  q_entry_t pop_data;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  vpa_front #(
    .NUM_VOICES (NUM_VOICES),
    .NUM_SOUNDS (NUM_SOUNDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .sound_id_i   (sound_id_i),
    .voice_sel_i  (voice_sel_i),
    .reserve_on_i (reserve_on_i),
    .q_full_i     (q_full),
    .q_push_o     (push),
    .q_entry_o    (push_data)
  );

  vpa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  vpa_back #(
    .NUM_VOICES   (NUM_VOICES),
    .NUM_RESERVED (NUM_RESERVED)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_entry_i    (pop_data),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .voice_out_o  (voice_out_o),
    .stole_busy_o (stole_busy_o),
    .granted_o    (granted_o)
  );

endmodule

/* rtl/vpa_checker.sv */
// ----------------------------------------------------------------------------
// vpa_port_checker
// Port-level checks of the voice pool allocator, bound to its top level.
// ----------------------------------------------------------------------------
module vpa_port_checker import vpa_pkg::*; #(
  parameter int NUM_VOICES = 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SEL_W-1:0] voice_out_o,
  input logic             stole_busy_o,
  input logic             granted_o
);

  // Front stage, queue, back stage and output register hold at most five.
  localparam int MAX_PEND = Q_DEPTH + 3;

  logic [3:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != '0))
    else $error("result delivered with no request outstanding");

  a_bounded_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(MAX_PEND))
    else $error("more requests outstanding than the design can hold");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(voice_out_o) && $stable(stole_busy_o) &&
       $stable(granted_o)))
    else $error("stalled result changed");

  a_steal_needs_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> !stole_busy_o)
    else $error("steal reported without a grant");

  a_voice_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> (32'(voice_out_o) < NUM_VOICES))
    else $error("granted voice out of range");

endmodule

bind voice_pool_allocator vpa_port_checker #(
  .NUM_VOICES (NUM_VOICES)
) u_vpa_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .voice_out_o  (voice_out_o),
  .stole_busy_o (stole_busy_o),
  .granted_o    (granted_o)
);
